>>> rtl/core/dd_odo_pkg.sv
// Shared types, constants and helpers for the differential drive odometry block.
package dd_odo_pkg;

	localparam int ATAN_COUNT = 24;

	localparam logic [17:0] HEAD_K      = 18'd174993;
	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
	localparam logic [52:0] DIST_HALF   = 53'd1000000;

	// distance divide: 2e6 = 128 * 15625, the odd part by reciprocal,
	// exact for 26-bit partial dividends
	localparam logic [13:0] DIST_ODD    = 14'd15625;
	localparam logic [26:0] DIST_RECIP  = 27'd70368745;

	// dividend size for the turn rate divider
	localparam logic [5:0] DIV_BITS_W = 6'd39;

	// register indexes
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_BASIS  = 1'b1;

	// one word handed from the front end to the back end
	typedef struct packed {
		logic signed [32:0] vnum;
		logic signed [23:0] w;
		logic signed [32:0] d;
		logic        [19:0] dt;
	} work_t;

	function automatic logic [29:0] atan_lookup(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v[33] && !(v[32] && v[31])) begin
			r = 32'sh8000_0000;
		end else if (!v[33] && (v[32] || v[31])) begin
			r = 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [23:0] sat_vel(input logic signed [27:0] v);
		logic signed [23:0] r;
		if (v[27] && !(&v[26:23])) begin
			r = 24'sh80_0000;
		end else if (!v[27] && (|v[26:23])) begin
			r = 24'sh7F_FFFF;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/dd_odo_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, MSB-aligned dividend.
module dd_odo_div import dd_odo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [52:0] dividend,
	input  logic [20:0] divisor,
	input  logic [5:0]  nbits,
	output logic        done,
	output logic [52:0] quotient
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [52:0] dvd_q;
	logic [20:0] div_q;
	logic [20:0] rem_q;
	logic [52:0] quo_q;
	logic        done_q;
	logic [21:0] rem_sh;
	logic        ge;
	logic [21:0] rem_sub;

	assign rem_sh  = {rem_q, dvd_q[52]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[20:0] : rem_sh[20:0];
			quo_q <= {quo_q[51:0], ge};
			dvd_q <= {dvd_q[51:0], 1'b0};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/dd_odo_cordic.sv
// Iterative rotation-mode CORDIC: 32-bit binary angle in, Q30 cos and sin out.
module dd_odo_cordic import dd_odo_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [33:0] cos_val,
	output logic signed [33:0] sin_val
);

	localparam int NSTEP = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;
	localparam logic [4:0] LAST = 5'(NSTEP - 1);

	logic               busy_q;
	logic               done_q;
	logic [4:0]         idx_q;
	logic               flip_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] xs, ys, at;
	logic               fold;
	logic [31:0]        ang_f;

	assign fold  = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
	assign ang_f = fold ? (angle ^ 32'h8000_0000) : angle;
	assign xs    = x_q >>> idx_q;
	assign ys    = y_q >>> idx_q;
	assign at    = $signed({4'd0, atan_lookup(idx_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (idx_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= fold;
			x_q    <= $signed({2'd0, CORDIC_GAIN});
			y_q    <= '0;
			z_q    <= $signed({{2{ang_f[31]}}, ang_f});
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

>>> rtl/core/dd_odo_front.sv
// Front end: config registers, input capture, speed and turn rate, travel distance.
module dd_odo_front import dd_odo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [17:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] left_wheel_rate,
	input  logic signed [15:0] right_wheel_rate,
	input  logic [19:0]        elapsed_time,
	input  logic               wq_full,
	output logic               wq_push,
	output work_t              wq_data
);

	typedef enum logic [2:0] {
		F_IDLE, F_MV, F_MW, F_DW, F_MD, F_SD, F_DD, F_PUSH
	} fstate_t;

	fstate_t            state_q;
	logic [15:0]        radius_q;
	logic [17:0]        basis_q;
	logic signed [15:0] wl_q, wr_q;
	logic [19:0]        dt_q;
	logic signed [32:0] vnum_q;
	logic signed [23:0] w_q;
	logic signed [32:0] d_q;
	logic signed [53:0] n_q;
	logic               neg_q;

	// distance divide: 12-bit digits, each in a multiply phase and a subtract phase
	logic [47:0]        dm_q;
	logic [13:0]        drem_q;
	logic [19:0]        dquo_q;
	logic [11:0]        ddig_q;
	logic [1:0]         dcnt_q;
	logic               dph_q;

	logic signed [16:0] r_s, sum_w, diff_w;
	logic signed [33:0] vprod, wprod, wmag;
	logic signed [53:0] nprod, nmag;
	logic               div_start, div_done;
	logic [52:0]        div_dvd, div_quo;
	logic [20:0]        div_dsr;
	logic [32:0]        q33;
	logic [52:0]        dsum;
	logic [25:0]        dv;
	logic [52:0]        dmul;
	logic [25:0]        dback;
	logic [25:0]        drem_full;

	assign r_s    = $signed({1'b0, radius_q});
	assign sum_w  = $signed({wr_q[15], wr_q}) + $signed({wl_q[15], wl_q});
	assign diff_w = $signed({wr_q[15], wr_q}) - $signed({wl_q[15], wl_q});
	assign vprod  = r_s * sum_w;
	assign wprod  = r_s * diff_w;
	assign wmag   = wprod[33] ? -wprod : wprod;
	assign nprod  = $signed({1'b0, dt_q}) * vnum_q;
	assign nmag   = n_q[53] ? -n_q : n_q;

	assign div_start = (state_q == F_MW);
	assign div_dvd   = {wmag[31:0], 21'd0};
	assign div_dsr   = (basis_q == '0) ? 21'd1 : {3'd0, basis_q};

	// rounded magnitude, then quotient digit = (rem:digit * recip) >> 40
	assign dsum      = nmag[52:0] + DIST_HALF;
	assign dv        = {drem_q, dm_q[47:36]};
	assign dmul      = {27'd0, dv} * {26'd0, DIST_RECIP};
	assign dback     = {14'd0, ddig_q} * {12'd0, DIST_ODD};
	assign drem_full = dv - dback;
	assign q33       = {1'b0, dquo_q, ddig_q};

	dd_odo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.nbits    (DIV_BITS_W),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			radius_q <= 16'd28000;
			basis_q  <= 18'd62500;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS: radius_q <= cfg_data[15:0];
					REG_BASIS:  basis_q  <= cfg_data;
					default:    ;
				endcase
			end
			case (state_q)
				F_IDLE: if (push) begin
					state_q <= F_MV;
				end
				F_MV:   state_q <= F_MW;
				F_MW:   state_q <= F_DW;
				F_DW:   if (div_done) begin
					state_q <= F_MD;
				end
				F_MD:   state_q <= F_SD;
				F_SD:   state_q <= F_DD;
				F_DD:   if (dph_q && (dcnt_q == 2'd3)) begin
					state_q <= F_PUSH;
				end
				F_PUSH: if (!wq_full) begin
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			wl_q <= left_wheel_rate;
			wr_q <= right_wheel_rate;
			dt_q <= elapsed_time;
		end
		if (state_q == F_MV) begin
			vnum_q <= vprod[32:0];
		end
		if (state_q == F_MW) begin
			neg_q <= wprod[33];
		end
		if (state_q == F_DW && div_done) begin
			if (!neg_q) begin
				w_q <= (div_quo > 53'd8388607) ? 24'sh7F_FFFF : div_quo[23:0];
			end else begin
				w_q <= (div_quo > 53'd8388608) ? 24'sh80_0000 : -div_quo[23:0];
			end
		end
		if (state_q == F_MD) begin
			n_q <= nprod;
		end
		if (state_q == F_SD) begin
			neg_q  <= n_q[53];
			dm_q   <= {2'b00, dsum[52:7]};
			drem_q <= '0;
			dquo_q <= '0;
			dcnt_q <= '0;
			dph_q  <= 1'b0;
		end
		if (state_q == F_DD) begin
			if (!dph_q) begin
				ddig_q <= dmul[51:40];
				dph_q  <= 1'b1;
			end else begin
				drem_q <= drem_full[13:0];
				dquo_q <= {dquo_q[7:0], ddig_q};
				dm_q   <= {dm_q[35:0], 12'd0};
				dcnt_q <= dcnt_q + 2'd1;
				dph_q  <= 1'b0;
				if (dcnt_q == 2'd3) begin
					d_q <= neg_q ? -q33 : q33;
				end
			end
		end
	end

	assign full         = (state_q != F_IDLE);
	assign wq_push      = (state_q == F_PUSH) && !wq_full;
	assign wq_data.vnum = vnum_q;
	assign wq_data.w    = w_q;
	assign wq_data.d    = d_q;
	assign wq_data.dt   = dt_q;

endmodule

>>> rtl/core/dd_odo_back.sv
// Back end: work queue, heading step, CORDIC pose update, velocity, result register.
module dd_odo_back import dd_odo_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wq_push,
	input  work_t              wq_data,
	output logic               wq_full,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0]        heading_angle,
	output logic signed [23:0] vel_x,
	output logic signed [23:0] vel_y,
	output logic signed [23:0] turn_rate
);

	typedef enum logic [3:0] {
		B_IDLE, B_P1, B_P2, B_P3, B_HEAD, B_COR1, B_MX, B_MY, B_AY,
		B_COR2, B_VX, B_VY, B_OUT
	} bstate_t;

	work_t       mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        take;

	bstate_t            state_q;
	work_t              cur_q;
	logic signed [44:0] m1_q;
	logic signed [63:0] p_q;
	logic [23:0]        full_q;
	logic signed [66:0] prod_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic [23:0]        acc_h_q;
	logic signed [23:0] vx_q;
	logic               out_valid_q;

	logic signed [41:0] ph_prod;
	logic [39:0]        pl_prod;
	logic [63:0]        half_sum, full_sum;
	logic [23:0]        mid, head_new;
	logic               cor_start, cor_done;
	logic [31:0]        cor_angle;
	logic signed [33:0] cos_v, sin_v, mul_b;
	logic signed [32:0] mul_a;
	logic signed [66:0] prod_w, rnd_pos, rnd_vel;
	logic signed [28:0] step;
	logic signed [33:0] sum_x, sum_y;
	logic               load_out;

	assign wq_full = (cnt_q == 2'd2);
	assign take    = (state_q == B_IDLE) && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (wq_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wq_push} - {1'b0, take};
		end
	end

	always_ff @(posedge clk) begin
		if (wq_push) begin
			mem_q[wr_ptr_q] <= wq_data;
		end
	end

	assign ph_prod  = $signed(m1_q[44:22]) * $signed({1'b0, HEAD_K});
	assign pl_prod  = m1_q[21:0] * HEAD_K;
	assign half_sum = p_q + 64'sd4294967296;
	assign full_sum = p_q + 64'sd2147483648;
	assign mid      = acc_h_q + half_sum[56:33];
	assign head_new = acc_h_q + full_q;

	assign cor_start = (state_q == B_HEAD) || (state_q == B_AY);
	assign cor_angle = (state_q == B_HEAD) ? {mid, 8'd0} : {head_new, 8'd0};

	dd_odo_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (cor_angle),
		.done    (cor_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	// one shared multiplier for the pose and velocity products
	assign mul_a   = ((state_q == B_MX) || (state_q == B_MY)) ? cur_q.d : cur_q.vnum;
	assign mul_b   = ((state_q == B_MX) || (state_q == B_VX)) ? cos_v : sin_v;
	assign prod_w  = mul_a * mul_b;
	assign rnd_pos = prod_q + (67'sd1 <<< 37);
	assign rnd_vel = prod_q + (67'sd1 <<< 38);
	assign step    = rnd_pos[66:38];
	assign sum_x   = {{2{acc_x_q[31]}}, acc_x_q} + {{5{step[28]}}, step};
	assign sum_y   = {{2{acc_y_q[31]}}, acc_y_q} + {{5{step[28]}}, step};
	assign load_out = (state_q == B_OUT) && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_h_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: if (take) begin
					state_q <= B_P1;
				end
				B_P1:   state_q <= B_P2;
				B_P2:   state_q <= B_P3;
				B_P3:   state_q <= B_HEAD;
				B_HEAD: state_q <= B_COR1;
				B_COR1: if (cor_done) begin
					state_q <= B_MX;
				end
				B_MX:   state_q <= B_MY;
				B_MY: begin
					acc_x_q <= sat_pos(sum_x);
					state_q <= B_AY;
				end
				B_AY: begin
					acc_y_q <= sat_pos(sum_y);
					acc_h_q <= head_new;
					state_q <= B_COR2;
				end
				B_COR2: if (cor_done) begin
					state_q <= B_VX;
				end
				B_VX:   state_q <= B_VY;
				B_VY:   state_q <= B_OUT;
				B_OUT:  if (load_out) begin
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= mem_q[rd_ptr_q];
		end
		if (state_q == B_P1) begin
			m1_q <= $signed({1'b0, cur_q.dt}) * cur_q.w;
		end
		if (state_q == B_P2) begin
			p_q <= {ph_prod, 22'd0};
		end
		if (state_q == B_P3) begin
			p_q <= p_q + $signed({24'd0, pl_prod});
		end
		if (state_q == B_HEAD) begin
			full_q <= full_sum[55:32];
		end
		if ((state_q == B_MX) || (state_q == B_MY) ||
			(state_q == B_VX) || (state_q == B_VY)) begin
			prod_q <= prod_w;
		end
		if (state_q == B_VY) begin
			vx_q <= sat_vel(rnd_vel[66:39]);
		end
		if (load_out) begin
			pos_x         <= acc_x_q;
			pos_y         <= acc_y_q;
			heading_angle <= acc_h_q[23:8];
			vel_x         <= vx_q;
			vel_y         <= sat_vel(rnd_vel[66:39]);
			turn_rate     <= cur_q.w;
		end
	end

	assign empty = !out_valid_q;

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		wq_full |-> !wq_push)
		else $error("work queue written while full");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("work queue count out of range");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(pos_x) && $stable(vel_y))
		else $error("waiting result lost or changed");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == B_COR1 || state_q == B_COR2))
		else $error("CORDIC finished outside a wait state");

endmodule

>>> rtl/core/differential_drive_odometry.sv
// Top level of the differential drive odometry block.
//
// Input channel: queue style. A word (left_wheel_rate, right_wheel_rate,
// elapsed_time) is taken on a clock edge with push high and full low.
// Result channel: queue style. While empty is low the ports carry the pose
// (pos_x, pos_y, heading_angle), world velocity (vel_x, vel_y) and turn_rate;
// the word is taken on an edge with pop high. One result per input word.
// Config: cfg_we writes cfg_data to register cfg_index (0 wheel radius,
// 1 half track width) at once; write only while the block is idle.
//
// The front end computes the turn rate with the one-bit-per-cycle divider
// (39 quotient bits), then the distance divide by 2e6 by reciprocal in four
// digit steps, plus its setup states. The back end makes two CORDIC runs on
// one unit (steps capped at 24). A two-word queue lets the front take the
// next word while the back works.
// Reset clears the pose to zero and loads radius 28000, half track 62500.
// If pop stays low the result is held, the back end stops in its last
// state, the queue fills and full stays high; nothing is dropped.
module differential_drive_odometry import dd_odo_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [17:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] left_wheel_rate,
	input  logic signed [15:0] right_wheel_rate,
	input  logic [19:0]        elapsed_time,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0]        heading_angle,
	output logic signed [23:0] vel_x,
	output logic signed [23:0] vel_y,
	output logic signed [23:0] turn_rate
);

	logic  wq_push;
	logic  wq_full;
	work_t wq_data;

	// front: w = r(wr-wl)*128/L through the divider, d = dt*r(wr+wl)/2e6 by reciprocal
	dd_odo_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.push             (push),
		.full             (full),
		.left_wheel_rate  (left_wheel_rate),
		.right_wheel_rate (right_wheel_rate),
		.elapsed_time     (elapsed_time),
		.wq_full          (wq_full),
		.wq_push          (wq_push),
		.wq_data          (wq_data)
	);

	// back: heading step, midpoint CORDIC, pose update, velocity CORDIC
	dd_odo_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.wq_push       (wq_push),
		.wq_data       (wq_data),
		.wq_full       (wq_full),
		.empty         (empty),
		.pop           (pop),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.heading_angle (heading_angle),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.turn_rate     (turn_rate)
	);

endmodule
